// ----- rtl/mpr_pkg.sv -----
// shared types, constants and helper functions for the masked pixel converter
`default_nettype none
package mpr_pkg;

	localparam int PIX_W     = 32;
	localparam int TZ_W      = $clog2(PIX_W);
	localparam int Q_W       = 8;
	localparam int NUM_W     = PIX_W + Q_W;
	localparam int DIV_STEPS = Q_W;
	localparam int N_STAGES  = DIV_STEPS + 2;
	localparam int BPP_W     = 6;
	localparam int ADDR_W    = 5;
	localparam int DATA_W    = 32;
	localparam int N_CHAN    = 4;

	localparam int CH_R = 0;
	localparam int CH_G = 1;
	localparam int CH_B = 2;
	localparam int CH_A = 3;

	localparam logic [PIX_W-1:0] RED_RST   = 32'h00FF_0000;
	localparam logic [PIX_W-1:0] GREEN_RST = 32'h0000_FF00;
	localparam logic [PIX_W-1:0] BLUE_RST  = 32'h0000_00FF;
	localparam logic [BPP_W-1:0] BPP_RST   = 6'd32;
	localparam logic             DEPTH_RST = 1'b1;

	typedef enum logic [2:0] {
		REG_RED,
		REG_GREEN,
		REG_BLUE,
		REG_BPP,
		REG_DEPTH
	} reg_idx_t;

	typedef enum logic [1:0] {
		MODE_SCALE,
		MODE_ZERO,
		MODE_FULL
	} chan_mode_t;

	typedef struct packed {
		logic [PIX_W-1:0] mask;
		logic [TZ_W-1:0]  tz;
		logic [PIX_W-1:0] maxv;
		chan_mode_t       mode;
	} chan_cfg_t;

	function automatic logic [TZ_W-1:0] trailing_zeros(input logic [PIX_W-1:0] m);
		logic [TZ_W-1:0] n;
		n = '0;
		for (int i = PIX_W - 1; i >= 0; i--) begin
			if (m[i]) n = TZ_W'(i);
		end
		return n;
	endfunction

	// low bpp bits set, all bits once bpp reaches the pixel width
	function automatic logic [PIX_W-1:0] pixel_span(input logic [BPP_W-1:0] bpp);
		logic [PIX_W-1:0] s;
		for (int i = 0; i < PIX_W; i++) begin
			s[i] = (BPP_W'(i) < bpp);
		end
		return s;
	endfunction

	function automatic chan_cfg_t make_chan(input logic [PIX_W-1:0] mask,
			input chan_mode_t mode);
		chan_cfg_t c;
		c.mask = mask;
		c.tz   = trailing_zeros(mask);
		c.maxv = mask >> c.tz;
		c.mode = mode;
		return c;
	endfunction

endpackage
`default_nettype wire

// ----- rtl/masked_pixel_to_rgba8.sv -----
// top level: masked raw pixel to 8-bit rgba converter
//
//  channel   signals                               width  role
//  cfg       psel penable pwrite paddr pwdata ...  32     register writes and reads
//  in        in_valid in_ready raw_pixel           32     raw pixel word
//  out       out_valid out_ready red/green/blue/alpha_out  4x8   converted word
//
// one word per cycle sustained unless out_ready stalls; one extract stage,
// one numerator stage and eight stages of a restoring divider, one quotient bit each.
// arst_n clears the valid bits and loads the register reset values.
// each stage holds while the one after it is full and stalled; bubbles are filled,
// so words keep entering while a finished word waits on out_ready.
`default_nettype none
module masked_pixel_to_rgba8 (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        psel,
	input  wire logic                        penable,
	input  wire logic                        pwrite,
	input  wire logic [mpr_pkg::ADDR_W-1:0]  paddr,
	input  wire logic [mpr_pkg::DATA_W-1:0]  pwdata,
	output logic      [mpr_pkg::DATA_W-1:0]  prdata,
	output logic                             pready,
	input  wire logic                        in_valid,
	output logic                             in_ready,
	input  wire logic [mpr_pkg::PIX_W-1:0]   raw_pixel,
	output logic                             out_valid,
	input  wire logic                        out_ready,
	output logic      [mpr_pkg::Q_W-1:0]     red_out,
	output logic      [mpr_pkg::Q_W-1:0]     green_out,
	output logic      [mpr_pkg::Q_W-1:0]     blue_out,
	output logic      [mpr_pkg::Q_W-1:0]     alpha_out
);
	import mpr_pkg::*;

	chan_cfg_t [N_CHAN-1:0] chan;
	logic [N_STAGES-1:0]    vld_s;
	logic [N_STAGES-1:0]    adv;
	logic [N_STAGES-1:0]    vld_in;
	logic [Q_W-1:0]         res [N_CHAN];

	mpr_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.chan    (chan)
	);

	for (genvar c = 0; c < N_CHAN; c++) begin : g_chan
		mpr_chan u_chan (
			.clk    (clk),
			.adv    (adv),
			.pixel  (raw_pixel),
			.cfg    (chan[c]),
			.result (res[c])
		);
	end

	// a stage moves when it is empty or the next one moves
	always_comb begin
		adv[N_STAGES-1] = !vld_s[N_STAGES-1] || out_ready;
		for (int i = N_STAGES - 2; i >= 0; i--) begin
			adv[i] = !vld_s[i] || adv[i+1];
		end
	end

	assign vld_in = {vld_s[N_STAGES-2:0], in_valid};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s <= '0;
		end else begin
			for (int i = 0; i < N_STAGES; i++) begin
				if (adv[i]) vld_s[i] <= vld_in[i];
			end
		end
	end

	assign in_ready  = adv[0];
	assign out_valid = vld_s[N_STAGES-1];
	assign red_out   = res[CH_R];
	assign green_out = res[CH_G];
	assign blue_out  = res[CH_B];
	assign alpha_out = res[CH_A];

	a_empty_tail_ready: assert property (@(posedge clk) disable iff (!arst_n)
		!vld_s[N_STAGES-1] |-> in_ready)
		else $error("input stalled with an empty output stage");

	a_accept_lands: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |=> vld_s[0])
		else $error("accepted word missing from the first stage");

	a_fill_step: assert property (@(posedge clk) disable iff (!arst_n)
		1'b1 |=> ($countones(vld_s) <= $countones($past(vld_s)) + 1 &&
			$countones(vld_s) + 1 >= $countones($past(vld_s))))
		else $error("pipeline occupancy jumped by more than one word");

endmodule
`default_nettype wire

// ----- rtl/mpr_cfg.sv -----
// register file for the channel masks with per-channel derived shift and maximum
`default_nettype none
module mpr_cfg (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         psel,
	input  wire logic                         penable,
	input  wire logic                         pwrite,
	input  wire logic [mpr_pkg::ADDR_W-1:0]   paddr,
	input  wire logic [mpr_pkg::DATA_W-1:0]   pwdata,
	output logic      [mpr_pkg::DATA_W-1:0]   prdata,
	output logic                              pready,
	output mpr_pkg::chan_cfg_t [mpr_pkg::N_CHAN-1:0] chan
);
	import mpr_pkg::*;

	logic [PIX_W-1:0] red_q, green_q, blue_q;
	logic [BPP_W-1:0] bpp_q;
	logic             depth_q;

	logic [PIX_W-1:0] red_n, green_n, blue_n;
	logic [BPP_W-1:0] bpp_n;
	logic             depth_n;
	logic             wr_en;
	reg_idx_t         idx;

	chan_cfg_t [N_CHAN-1:0] chan_q, chan_n;
	logic [PIX_W-1:0]       alpha_n, alpha_rst;

	assign pready = 1'b1;
	assign wr_en  = psel && penable && pwrite;
	assign idx    = reg_idx_t'(paddr[ADDR_W-1:2]);

	always_comb begin
		red_n   = red_q;
		green_n = green_q;
		blue_n  = blue_q;
		bpp_n   = bpp_q;
		depth_n = depth_q;
		if (wr_en) begin
			unique case (idx)
				REG_RED:   red_n   = pwdata[PIX_W-1:0];
				REG_GREEN: green_n = pwdata[PIX_W-1:0];
				REG_BLUE:  blue_n  = pwdata[PIX_W-1:0];
				REG_BPP:   bpp_n   = pwdata[BPP_W-1:0];
				REG_DEPTH: depth_n = pwdata[0];
				default:   ;
			endcase
		end
	end

	// derived values follow the write in the same edge so an item right after sees them
	always_comb begin
		alpha_n   = pixel_span(bpp_n) & ~(red_n | green_n | blue_n);
		alpha_rst = pixel_span(BPP_RST) & ~(RED_RST | GREEN_RST | BLUE_RST);
		chan_n[CH_R] = make_chan(red_n,   (red_n   != '0) ? MODE_SCALE : MODE_ZERO);
		chan_n[CH_G] = make_chan(green_n, (green_n != '0) ? MODE_SCALE : MODE_ZERO);
		chan_n[CH_B] = make_chan(blue_n,  (blue_n  != '0) ? MODE_SCALE : MODE_ZERO);
		chan_n[CH_A] = make_chan(alpha_n,
			(depth_n && alpha_n != '0) ? MODE_SCALE : MODE_FULL);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			red_q        <= RED_RST;
			green_q      <= GREEN_RST;
			blue_q       <= BLUE_RST;
			bpp_q        <= BPP_RST;
			depth_q      <= DEPTH_RST;
			chan_q[CH_R] <= make_chan(RED_RST, MODE_SCALE);
			chan_q[CH_G] <= make_chan(GREEN_RST, MODE_SCALE);
			chan_q[CH_B] <= make_chan(BLUE_RST, MODE_SCALE);
			chan_q[CH_A] <= make_chan(alpha_rst,
				(DEPTH_RST && alpha_rst != '0) ? MODE_SCALE : MODE_FULL);
		end else begin
			red_q   <= red_n;
			green_q <= green_n;
			blue_q  <= blue_n;
			bpp_q   <= bpp_n;
			depth_q <= depth_n;
			chan_q  <= chan_n;
		end
	end

	assign chan = chan_q;

	always_comb begin
		prdata = '0;
		unique case (idx)
			REG_RED:   prdata = DATA_W'(red_q);
			REG_GREEN: prdata = DATA_W'(green_q);
			REG_BLUE:  prdata = DATA_W'(blue_q);
			REG_BPP:   prdata = DATA_W'(bpp_q);
			REG_DEPTH: prdata = DATA_W'(depth_q);
			default:   prdata = '0;
		endcase
	end

endmodule
`default_nettype wire

// ----- rtl/mpr_chan.sv -----
// one channel: extract by mask, form rounded numerator, restoring divide one bit per stage
`default_nettype none
module mpr_chan (
	input  wire logic                          clk,
	input  wire logic [mpr_pkg::N_STAGES-1:0]  adv,
	input  wire logic [mpr_pkg::PIX_W-1:0]     pixel,
	input  wire mpr_pkg::chan_cfg_t            cfg,
	output logic      [mpr_pkg::Q_W-1:0]       result
);
	import mpr_pkg::*;

	logic [PIX_W-1:0] val_s1;
	logic [NUM_W-1:0] num_s2;
	// divider stages 3 and up, index 0 is stage 3
	logic [NUM_W-1:0] rem_s [DIV_STEPS-1];
	logic [Q_W-1:0]   quo_s [DIV_STEPS];

	always_ff @(posedge clk) begin
		if (adv[0]) val_s1 <= (pixel & cfg.mask) >> cfg.tz;
	end

	// value*255 + max/2
	always_ff @(posedge clk) begin
		if (adv[1]) begin
			num_s2 <= (NUM_W'(val_s1) << Q_W) - NUM_W'(val_s1) + NUM_W'(cfg.maxv >> 1);
		end
	end

	for (genvar j = 0; j < DIV_STEPS; j++) begin : g_div
		logic [NUM_W-1:0] rin, dsh;
		logic [Q_W-1:0]   qin;
		logic             ge;

		if (j == 0) begin : g_first
			assign rin = num_s2;
			assign qin = '0;
		end else begin : g_next
			assign rin = rem_s[j-1];
			assign qin = quo_s[j-1];
		end

		assign dsh = NUM_W'(cfg.maxv) << (DIV_STEPS - 1 - j);
		assign ge  = (rin >= dsh);

		always_ff @(posedge clk) begin
			if (adv[j+2]) quo_s[j] <= qin | (Q_W'(ge) << (DIV_STEPS - 1 - j));
		end

		if (j < DIV_STEPS - 1) begin : g_rem
			always_ff @(posedge clk) begin
				if (adv[j+2]) rem_s[j] <= ge ? (rin - dsh) : rin;
			end
		end
	end

	always_comb begin
		unique case (cfg.mode)
			MODE_SCALE: result = quo_s[DIV_STEPS-1];
			MODE_ZERO:  result = '0;
			MODE_FULL:  result = '1;
			default:    result = '0;
		endcase
	end

endmodule
`default_nettype wire

// ----- bench/masked_pixel_to_rgba8_tb.sv -----
`timescale 1ns / 100ps
// self-checking testbench for masked_pixel_to_rgba8: predicted rgba words vs the block
module masked_pixel_to_rgba8_tb;
	import mpr_pkg::*;

	localparam int         CYCLE_LIMIT  = 400000;
	localparam int         DRAIN_CYCLES = 20;
	localparam int         SET_COUNT    = 24;
	localparam int         SET_WORDS    = 50;
	localparam logic [2:0] SPARE_REG    = 3'd7;

	typedef struct packed {
		logic [Q_W-1:0] red;
		logic [Q_W-1:0] green;
		logic [Q_W-1:0] blue;
		logic [Q_W-1:0] alpha;
	} rgba_t;

	logic              clk;
	logic              arst_n;
	logic              psel;
	logic              penable;
	logic              pwrite;
	logic [ADDR_W-1:0] paddr;
	logic [DATA_W-1:0] pwdata;
	logic [DATA_W-1:0] prdata;
	logic              pready;
	logic              in_valid;
	logic              in_ready;
	logic [PIX_W-1:0]  raw_pixel;
	logic              out_valid;
	logic              out_ready;
	logic [Q_W-1:0]    red_out;
	logic [Q_W-1:0]    green_out;
	logic [Q_W-1:0]    blue_out;
	logic [Q_W-1:0]    alpha_out;

	// predictor copy of the registers
	logic [PIX_W-1:0] red_mask_q   = RED_RST;
	logic [PIX_W-1:0] green_mask_q = GREEN_RST;
	logic [PIX_W-1:0] blue_mask_q  = BLUE_RST;
	logic [BPP_W-1:0] bpp_q        = BPP_RST;
	logic             depth_q      = DEPTH_RST;

	rgba_t       expected_rgba[$];
	int          err_count      = 0;
	int          send_idle_pct  = 0;
	int          recv_stall_pct = 0;
	int          hold_left      = 0;
	int unsigned cycle_count    = 0;

	masked_pixel_to_rgba8 dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.psel      (psel),
		.penable   (penable),
		.pwrite    (pwrite),
		.paddr     (paddr),
		.pwdata    (pwdata),
		.prdata    (prdata),
		.pready    (pready),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.raw_pixel (raw_pixel),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.red_out   (red_out),
		.green_out (green_out),
		.blue_out  (blue_out),
		.alpha_out (alpha_out)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// pull the masked field down to bit 0 and rescale 0..max onto 0..255 with rounding
	function automatic logic [Q_W-1:0] rescale_field(input logic [PIX_W-1:0] px,
			input logic [PIX_W-1:0] m);
		logic [63:0] ch_val;
		logic [63:0] ch_max;
		int          sh;
		if (m == '0) return '0;
		sh = 0;
		while (!m[sh]) sh++;
		ch_val = 64'(px & m) >> sh;
		ch_max = 64'(m) >> sh;
		return Q_W'((ch_val * 255 + ch_max / 2) / ch_max);
	endfunction

	function automatic rgba_t predict_rgba(input logic [PIX_W-1:0] px);
		rgba_t            w;
		logic [PIX_W-1:0] span;
		logic [PIX_W-1:0] alpha_bits;
		if (bpp_q >= BPP_W'(PIX_W))
			span = '1;
		else
			span = PIX_W'((64'd1 << bpp_q) - 1);
		alpha_bits = span & ~(red_mask_q | green_mask_q | blue_mask_q);
		w.red   = rescale_field(px, red_mask_q);
		w.green = rescale_field(px, green_mask_q);
		w.blue  = rescale_field(px, blue_mask_q);
		w.alpha = (depth_q && alpha_bits != '0) ? rescale_field(px, alpha_bits) : 8'hFF;
		return w;
	endfunction

	task automatic write_reg(input logic [2:0] idx, input logic [DATA_W-1:0] val);
		@(negedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {idx, 2'b00};
		pwdata  <= val;
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		case (idx)
			REG_RED:   red_mask_q   = val;
			REG_GREEN: green_mask_q = val;
			REG_BLUE:  blue_mask_q  = val;
			REG_BPP:   bpp_q        = val[BPP_W-1:0];
			REG_DEPTH: depth_q      = val[0];
			default: ;
		endcase
		@(negedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
	endtask

	task automatic write_format(input logic [PIX_W-1:0] r, input logic [PIX_W-1:0] g,
			input logic [PIX_W-1:0] b, input int bpp, input logic depth);
		write_reg(REG_RED, r);
		write_reg(REG_GREEN, g);
		write_reg(REG_BLUE, b);
		write_reg(REG_BPP, DATA_W'(bpp));
		write_reg(REG_DEPTH, DATA_W'(depth));
	endtask

	task automatic set_idling(input int send_pct, input int stall_pct);
		send_idle_pct  = send_pct;
		recv_stall_pct = stall_pct;
	endtask

	task automatic send_pixel(input logic [PIX_W-1:0] px);
		@(negedge clk);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid  <= 1'b1;
		raw_pixel <= px;
		do @(posedge clk); while (!in_ready);
		expected_rgba.push_back(predict_rgba(px));
	endtask

	// drop valid and wait until every word has come back
	task automatic drain_pipe();
		@(negedge clk);
		in_valid <= 1'b0;
		while (expected_rgba.size() != 0) @(posedge clk);
	endtask

	function automatic logic [PIX_W-1:0] rand_mask();
		int lo;
		int len;
		lo  = $urandom_range(31);
		len = $urandom_range(32 - lo, 1);
		case ($urandom_range(5))
			0: return '0;
			1: return '1;
			2: return $urandom;
			3: return PIX_W'(1) << lo;
			default: return PIX_W'(((64'd1 << len) - 1) << lo);
		endcase
	endfunction

	function automatic int rand_bpp();
		case ($urandom_range(3))
			0: begin
				case ($urandom_range(5))
					0: return 0;
					1: return 1;
					2: return 31;
					3: return 32;
					4: return 33;
					default: return 63;
				endcase
			end
			1: return $urandom_range(63);
			default: return $urandom_range(32, 1);
		endcase
	endfunction

	function automatic logic [PIX_W-1:0] rand_pixel();
		case ($urandom_range(9))
			0: return '0;
			1: return '1;
			2: return red_mask_q | blue_mask_q;
			3: return ~green_mask_q;
			default: return $urandom;
		endcase
	endfunction

	task automatic write_random_format();
		logic depth;
		depth = $urandom_range(1);
		case ($urandom_range(6))
			0: write_format(32'h0000_F800, 32'h0000_07E0, 32'h0000_001F, 16, depth);
			1: write_format(32'h00FF_0000, 32'h0000_FF00, 32'h0000_00FF, 32, depth);
			2: write_format(32'h3FF0_0000, 32'h000F_FC00, 32'h0000_03FF, 32, depth);
			3: write_format(32'h0000_00FF, 32'h0000_FF00, 32'h00FF_0000, 24, depth);
			4: write_format(32'h0000_7C00, 32'h0000_03E0, 32'h0000_001F, 16, depth);
			default: write_format(rand_mask(), rand_mask(), rand_mask(), rand_bpp(), depth);
		endcase
	endtask

	task automatic test_reset_format();
		set_idling(0, 0);
		send_pixel(32'h0000_0000);
		send_pixel(32'hFFFF_FFFF);
		send_pixel(32'h1234_5678);
		send_pixel(32'h8080_8080);
		send_pixel(32'hAAAA_AAAA);
		send_pixel(32'h5555_5555);
		drain_pipe();
	endtask

	// no color masks: alpha takes the whole 32-bit word
	task automatic test_empty_masks();
		write_format('0, '0, '0, 32, 1'b1);
		send_pixel(32'h0000_0000);
		send_pixel(32'hFFFF_FFFF);
		send_pixel(32'h8000_0000);
		send_pixel(32'h7FFF_FFFF);
		drain_pipe();
	endtask

	task automatic test_pixel_count_edges();
		write_format(32'h0000_F800, 32'h0000_07E0, 32'h0000_001F, 16, 1'b1);
		// upper register bits must be dropped: bpp reads as 0, alpha forced full
		write_reg(REG_BPP, 32'hFFFF_FFC0);
		send_pixel(32'hFFFF_FFFF);
		send_pixel(32'h0001_0000);
		drain_pipe();
		// bpp 40 is wider than the pixel, alpha covers the upper half
		write_reg(REG_BPP, 32'h0000_0068);
		send_pixel(32'hFFFF_0000);
		send_pixel(32'h8001_2345);
		drain_pipe();
		write_reg(REG_BPP, 32'd63);
		send_pixel(32'h7FFF_A5A5);
		drain_pipe();
		// one alpha bit just above the 565 fields
		write_reg(REG_BPP, 32'd17);
		send_pixel(32'h0001_FFFF);
		send_pixel(32'hFFFE_0000);
		drain_pipe();
		write_reg(REG_DEPTH, 32'hFFFF_FFFE);
		send_pixel(32'h0001_FFFF);
		send_pixel(32'h0000_0000);
		drain_pipe();
		// write to an unmapped address leaves every register alone
		write_reg(SPARE_REG, 32'h0000_0000);
		send_pixel(32'hFFFF_FFFF);
		drain_pipe();
	endtask

	task automatic test_random_formats();
		for (int set_no = 0; set_no < SET_COUNT; set_no++) begin
			case (set_no % 4)
				0: set_idling(0, 0);
				1: set_idling(69, 0);
				2: set_idling(0, 69);
				default: set_idling(38, 38);
			endcase
			write_random_format();
			repeat (SET_WORDS) send_pixel(rand_pixel());
			drain_pipe();
		end
	endtask

	// long output stall while words keep coming, so the pipe fills and in_ready drops
	task automatic test_output_stall();
		set_idling(0, 0);
		write_random_format();
		hold_left = 300;
		repeat (60) send_pixel(rand_pixel());
		drain_pipe();
	endtask

	initial begin
		out_ready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_left > 0) begin
				out_ready <= 1'b0;
				hold_left--;
			end else begin
				out_ready <= ($urandom_range(99) >= recv_stall_pct);
			end
		end
	end

	always @(posedge clk) begin : check_word
		rgba_t got;
		rgba_t want;
		string field_name [4];
		field_name = '{"red_out", "green_out", "blue_out", "alpha_out"};
		if (arst_n && out_valid && out_ready) begin
			got = '{red_out, green_out, blue_out, alpha_out};
			if (expected_rgba.size() == 0) begin
				err_count++;
				$display("%0t: unexpected word, got %08h", $time, got);
			end else begin
				want = expected_rgba.pop_front();
				for (int i = 0; i < 4; i++) begin
					if (got[31-8*i -: 8] !== want[31-8*i -: 8]) begin
						err_count++;
						$display("%0t: %s expected %02h got %02h", $time, field_name[i],
							want[31-8*i -: 8], got[31-8*i -: 8]);
					end
				end
			end
		end
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("masked_pixel_to_rgba8: mismatch");
			$finish;
		end
	end

	initial begin
		arst_n    = 1'b0;
		psel      = 1'b0;
		penable   = 1'b0;
		pwrite    = 1'b0;
		paddr     = '0;
		pwdata    = '0;
		in_valid  = 1'b0;
		raw_pixel = '0;
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		test_reset_format();
		test_empty_masks();
		test_pixel_count_edges();
		test_random_formats();
		test_output_stall();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (err_count == 0)
			$display("masked_pixel_to_rgba8: match");
		else
			$display("masked_pixel_to_rgba8: mismatch");
		$finish;
	end

endmodule

// ----- files.f -----
rtl/mpr_pkg.sv
rtl/mpr_cfg.sv
rtl/mpr_chan.sv
rtl/masked_pixel_to_rgba8.sv
bench/masked_pixel_to_rgba8_tb.sv
